// ===== src/cwpg_pkg.sv =====
package cwpg_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND    = 2'd2;

  // Field widths.
  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int RGB_W  = 24;
  localparam int CHAN_W = 8;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] CANVAS_RESET = 13'd256;
  localparam logic [RGB_W-1:0] BG_RESET     = 24'hFFFFFF;

  // Tangent of whole degrees 0..44, scaled by 10^12.
  localparam int TAN_W = 40;
  localparam int TAN_LAST = 44;
  localparam logic [TAN_W-1:0] TAN_SCALE = 40'd1000000000000;
  localparam logic [TAN_W-1:0] TAN_DEG [0:TAN_LAST] = '{
    40'd0,
    40'd17455064928,  40'd34920769492,  40'd52407779283,  40'd69926811944,
    40'd87488663526,  40'd105104235266, 40'd122784560903, 40'd140540834702,
    40'd158384440325, 40'd176326980708, 40'd194380309138, 40'd212556561670,
    40'd230868191126, 40'd249328002843, 40'd267949192431, 40'd286745385759,
    40'd305730681459, 40'd324919696233, 40'd344327613290, 40'd363970234266,
    40'd383864035035, 40'd404026225835, 40'd424474816209, 40'd445228685309,
    40'd466307658155, 40'd487732588566, 40'd509525449494, 40'd531709431661,
    40'd554309051453, 40'd577350269190, 40'd600860619028, 40'd624869351910,
    40'd649407593198, 40'd674508516842, 40'd700207538210, 40'd726542528005,
    40'd753554050103, 40'd781285626507, 40'd809784033195, 40'd839099631177,
    40'd869286737816, 40'd900404044298, 40'd932515086138, 40'd965688774807
  };

  // Table read that gives all ones past the last degree.
  function automatic logic [TAN_W-1:0] tan_lookup(input logic [6:0] idx);
    logic [TAN_W-1:0] val;
    val = '1;
    if (idx <= 7'(TAN_LAST)) begin
      val = TAN_DEG[idx[5:0]];
    end
    return val;
  endfunction

endpackage

// ===== src/color_wheel_pixel_generator_core.sv =====
// Channel | Dir | Handshake          | Payload
// in_     | in  | tvalid / tready    | tdata: pixel_x, pixel_y
// out_    | out | tvalid / tready    | tdata: red, green, blue; tuser: on_wheel
// cfg_    | in  | valid / ready      | index, data
//
// One pixel enters per clock while the output is not stalled; the pipeline length is
// set by the one-bit-per-stage divider and square root chains.
// Reset (rst_n low, synchronous) empties the pipeline and restores the registers.
// A stall on the output holds every stage in place; in_tready follows it in the same cycle.
// Configuration writes are always taken; cfg_ready is tied high.
module color_wheel_pixel_generator_core
  import cwpg_pkg::*;
#(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x[11:0], pixel_y[23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red[7:0], green[15:8], blue[23:16]
  output logic        out_tuser,  // on_wheel[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int F   = FRAC_BITS;
  localparam int RW  = $clog2(MAX_DIM);
  localparam int AW  = (RW > PIX_W) ? RW : PIX_W;
  localparam int WW  = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam int LW  = 2 * RW + 7;
  localparam int NW  = 2 * AW + 8;
  localparam int VW  = AW + TAN_W;

  // Stage positions.
  localparam int SRCH0 = 3;
  localparam int DIV0  = SRCH0 + 1;
  localparam int SQ0   = DIV0 + 2 * F + 1;
  localparam int HUE0  = SRCH0 + 12;
  localparam int SFIN  = SQ0 + F + 1;
  localparam int NST   = SFIN + 3;

  localparam logic [F:0] ONE = (F+1)'(1) << F;

  typedef struct packed {
    logic signed [AW:0] dx;
    logic signed [AW:0] dy;
    logic [AW-1:0]      ax;
    logic [AW-1:0]      ay;
    logic               negx;
    logic               negy;
    logic               swap;
    logic [AW-1:0]      u;
    logic [AW-1:0]      v;
    logic [2*AW-1:0]    dxsq;
    logic [2*AW-1:0]    dysq;
    logic [2*AW:0]      dsq;
    logic [VW-1:0]      vs;
    logic [VW-1:0]      prod;
    logic [5:0]         lo;
    logic               off;
    logic               zl;
    logic [NW-1:0]      rem;
    logic [2*F+1:0]     qv;
    logic [F+2:0]       srem;
    logic [F:0]         root;
    logic [8:0]         hue;
    logic [2:0]         sector;
    logic [5:0]         hrem;
    logic [F-1:0]       f;
    logic [F:0]         s;
    logic [2*F:0]       pf;
    logic [2*F+1:0]     pg;
    logic [F:0]         vr;
    logic [F:0]         vg;
    logic [F:0]         vb;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               ow;
  } item_t;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [RGB_W-1:0] bg_r;
  logic [2*RW-1:0]  r_sq_r;
  logic [LW-1:0]    lim_r;

  logic [WW-1:0]    w_clamp;
  logic [WW-1:0]    h_clamp;
  logic [RW-1:0]    cx;
  logic [RW-1:0]    cy;
  logic [RW-1:0]    rad;

  item_t            pipe_r [NST];
  item_t            pipe_nxt [NST];
  logic [NST-1:0]   vld_r;
  logic             adv;
  item_t            in_item;
  logic [F-1:0]     f_tab [60];

  // Fraction of a sector for each degree within it.
  for (genvar gi = 0; gi < 60; gi++) begin : g_ftab
    localparam logic [F-1:0] FV = F'((gi * (64'd1 << F)) / 60);
    assign f_tab[gi] = FV;
  end

  function automatic logic [7:0] chan(input logic [F:0] x);
    logic [F+8:0] w;
    w = {x, 8'b0} - (F+9)'(x);
    return w[F+7:F];
  endfunction

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CANVAS_RESET;
      height_r <= CANVAS_RESET;
      bg_r     <= BG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CANVAS_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        CFG_CANVAS_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        CFG_BACKGROUND:    bg_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wheel center and radius from the canvas size.
  always_comb begin
    w_clamp = (int'(width_r) > MAX_DIM) ? WW'(MAX_DIM) : WW'(width_r);
    h_clamp = (int'(height_r) > MAX_DIM) ? WW'(MAX_DIM) : WW'(height_r);
    cx = RW'(w_clamp >> 1);
    cy = RW'(h_clamp >> 1);
    rad = (cx < cy) ? cx : cy;
  end

  // Squared radius limit, 81*r*r, followed over two registers.
  always_ff @(posedge clk) begin
    r_sq_r <= rad * rad;
    lim_r  <= (LW'(r_sq_r) << 6) + (LW'(r_sq_r) << 4) + LW'(r_sq_r);
  end

  assign adv = !vld_r[NST-1] || out_tready;
  assign in_tready = adv;

  // Offsets from the center for the incoming pixel.
  always_comb begin
    in_item = '0;
    in_item.dx = signed'((AW+1)'(in_tdata[11:0])) - signed'((AW+1)'(cx));
    in_item.dy = signed'((AW+1)'(in_tdata[23:12])) - signed'((AW+1)'(cy));
  end

  // Work of every stage.
  always_comb begin
    item_t          it;
    int             j;
    int             di;
    logic [6:0]     cand;
    logic [NW-1:0]  dt;
    logic           qbit;
    logic [F+4:0]   r2;
    logic [F+4:0]   tr;
    logic [7:0]     fl;
    logic [7:0]     cl;
    logic [7:0]     fb;
    logic [7:0]     cb;
    logic [8:0]     fa;
    logic [NW-1:0]  num;
    for (int k = 0; k < NST; k++) begin
      j    = 0;
      di   = 0;
      cand = '0;
      dt   = '0;
      qbit = 1'b0;
      r2   = '0;
      tr   = '0;
      fl   = '0;
      cl   = '0;
      fb   = '0;
      cb   = '0;
      fa   = '0;
      num  = '0;
      if (k == 0) begin
        it = in_item;
      end else begin
        it = pipe_r[(k == 0) ? 0 : k - 1];
      end

      // Magnitudes, octant and squares.
      if (k == 1) begin
        it.negx = it.dx[AW];
        it.negy = it.dy[AW];
        it.ax = it.dx[AW] ? AW'(-it.dx) : AW'(it.dx);
        it.ay = it.dy[AW] ? AW'(-it.dy) : AW'(it.dy);
        it.swap = it.ay > it.ax;
        it.u = it.swap ? it.ay : it.ax;
        it.v = it.swap ? it.ax : it.ay;
        it.dxsq = it.ax * it.ax;
        it.dysq = it.ay * it.ay;
      end

      if (k == 2) begin
        it.dsq = (2*AW+1)'(it.dxsq) + (2*AW+1)'(it.dysq);
        it.vs = VW'(it.v) * VW'(TAN_SCALE);
        it.lo = '0;
      end

      // Wheel test and divider load.
      if (k == SRCH0) begin
        num = (NW'(it.dsq) << 6) + (NW'(it.dsq) << 5) + (NW'(it.dsq) << 2);
        it.off = num > NW'(lim_r);
        it.zl = (lim_r == '0);
        it.rem = num;
        it.qv = '0;
      end

      // Binary search for the whole degree: product, then compare.
      if (k >= SRCH0 && k < SRCH0 + 12) begin
        j = (k - SRCH0) >> 1;
        cand = 7'(it.lo) + (7'd1 << (5 - j));
        if (((k - SRCH0) & 1) == 0) begin
          it.prod = VW'(tan_lookup(cand)) * VW'(it.u);
        end else if (cand <= 7'(TAN_LAST) && it.vs >= it.prod) begin
          it.lo = cand[5:0];
        end
      end

      // Hue in degrees from the octant angle; an axis or the diagonal gives an exact angle.
      if (k == HUE0) begin
        if (it.u == '0 || it.v == '0) begin
          fl = 8'd0;
          cl = 8'd0;
        end else if (it.u == it.v) begin
          fl = 8'd45;
          cl = 8'd45;
        end else begin
          fl = 8'(it.lo);
          cl = 8'(it.lo) + 8'd1;
        end
        fb = it.swap ? 8'd90 - cl : fl;
        cb = it.swap ? 8'd90 - fl : cl;
        fa = it.negx ? 9'd180 - 9'(cb) : 9'(fb);
        it.hue = (it.negy && fa != '0) ? 9'd360 - fa : fa;
      end

      if (k == HUE0 + 1) begin
        priority if (it.hue >= 9'd300) begin
          it.sector = 3'd5;
          it.hrem = 6'(it.hue - 9'd300);
        end else if (it.hue >= 9'd240) begin
          it.sector = 3'd4;
          it.hrem = 6'(it.hue - 9'd240);
        end else if (it.hue >= 9'd180) begin
          it.sector = 3'd3;
          it.hrem = 6'(it.hue - 9'd180);
        end else if (it.hue >= 9'd120) begin
          it.sector = 3'd2;
          it.hrem = 6'(it.hue - 9'd120);
        end else if (it.hue >= 9'd60) begin
          it.sector = 3'd1;
          it.hrem = 6'(it.hue - 9'd60);
        end else begin
          it.sector = 3'd0;
          it.hrem = 6'(it.hue);
        end
      end

      if (k == HUE0 + 2) begin
        it.f = f_tab[it.hrem];
      end

      // Restoring division, one quotient bit per stage.
      if (k >= DIV0 && k <= DIV0 + 2 * F) begin
        di = k - DIV0;
        dt = (di == 0) ? it.rem : (it.rem << 1);
        qbit = dt >= NW'(lim_r);
        if (qbit) begin
          dt = dt - NW'(lim_r);
        end
        it.rem = dt;
        it.qv = {it.qv[2*F:0], qbit};
      end

      // Square root, one result bit per stage.
      if (k >= SQ0 && k <= SQ0 + F) begin
        if (k == SQ0) begin
          it.srem = '0;
          it.root = '0;
        end
        r2 = {it.srem, it.qv[2*F+1:2*F]};
        tr = (F+5)'({it.root, 2'b01});
        if (r2 >= tr) begin
          it.srem = (F+3)'(r2 - tr);
          it.root = {it.root[F-1:0], 1'b1};
        end else begin
          it.srem = (F+3)'(r2);
          it.root = {it.root[F-1:0], 1'b0};
        end
        it.qv = it.qv << 2;
      end

      // Saturation and the two products.
      if (k == SFIN) begin
        it.s = it.zl ? '0 : ((it.root > ONE) ? ONE : it.root);
        it.pf = it.s * it.f;
        it.pg = it.s * (ONE - (F+1)'(it.f));
      end

      if (k == SFIN + 1) begin
        unique case (it.sector)
          3'd0: begin
            it.vr = ONE;
            it.vg = ONE - (F+1)'(it.pg >> F);
            it.vb = ONE - it.s;
          end
          3'd1: begin
            it.vr = ONE - (F+1)'(it.pf >> F);
            it.vg = ONE;
            it.vb = ONE - it.s;
          end
          3'd2: begin
            it.vr = ONE - it.s;
            it.vg = ONE;
            it.vb = ONE - (F+1)'(it.pg >> F);
          end
          3'd3: begin
            it.vr = ONE - it.s;
            it.vg = ONE - (F+1)'(it.pf >> F);
            it.vb = ONE;
          end
          3'd4: begin
            it.vr = ONE - (F+1)'(it.pg >> F);
            it.vg = ONE - it.s;
            it.vb = ONE;
          end
          default: begin
            it.vr = ONE;
            it.vg = ONE - it.s;
            it.vb = ONE - (F+1)'(it.pf >> F);
          end
        endcase
      end

      // Channel bytes, or the background off the wheel.
      if (k == SFIN + 2) begin
        it.ow = !it.off;
        if (it.off) begin
          it.red   = bg_r[23:16];
          it.green = bg_r[15:8];
          it.blue  = bg_r[7:0];
        end else begin
          it.red   = chan(it.vr);
          it.green = chan(it.vg);
          it.blue  = chan(it.vb);
        end
      end

      pipe_nxt[k] = it;
    end
  end

  // Pipeline registers; everything holds while the output is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {pipe_r[NST-1].blue, pipe_r[NST-1].green, pipe_r[NST-1].red};
  assign out_tuser  = pipe_r[NST-1].ow;

  // With a nonzero radius, the square root of an on-wheel ratio never passes one.
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SFIN-1] && !pipe_r[SFIN-1].off && !pipe_r[SFIN-1].zl |->
      pipe_r[SFIN-1].root <= ONE)
    else $error("square root above one on the wheel");

  // The divider remainder ends below the limit.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ0-1] && !pipe_r[SQ0-1].off && !pipe_r[SQ0-1].zl |->
      pipe_r[SQ0-1].rem < NW'(lim_r))
    else $error("divider remainder not below limit");

  // Hue stays within a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[HUE0] |-> pipe_r[HUE0].hue < 9'd360)
    else $error("hue out of range");

  // Full value: an on-wheel pixel has at least one channel at its peak.
  a_full_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[7:0] == 8'hFF || out_tdata[15:8] == 8'hFF || out_tdata[23:16] == 8'hFF))
    else $error("on-wheel pixel without a full channel");

  // A stall freezes the valid bits of every stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

endmodule

// ===== tb/sv/tb_color_wheel_pixel_generator_core.sv =====
`timescale 1ns / 100ps

module tb_color_wheel_pixel_generator_core;
  import cwpg_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 3 * FRAC + 9;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [16:0] ONE = 17'h10000;

  // One expected pixel color.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       on_wheel;
  } pixel_color_t;

  // One row of the directed table; has_color marks a hand-typed result.
  typedef struct {
    logic [11:0]  px;
    logic [11:0]  py;
    bit           has_color;
    pixel_color_t color;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  // Shadow copy of the configuration registers.
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] bg_reg;

  pixel_color_t color_queue[$];
  int mismatch_count;
  int unexpected_count;
  int in_idle_pct;
  int out_idle_pct;
  bit hold_off;
  int quiet_cycles;

  color_wheel_pixel_generator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Tangents of whole degrees, scaled by 10^12.
  function automatic logic [63:0] tan_scaled(input int d);
    logic [63:0] tbl [0:44];
    tbl = '{64'd0,
      64'd17455064928,  64'd34920769492,  64'd52407779283,  64'd69926811944,
      64'd87488663526,  64'd105104235266, 64'd122784560903, 64'd140540834702,
      64'd158384440325, 64'd176326980708, 64'd194380309138, 64'd212556561670,
      64'd230868191126, 64'd249328002843, 64'd267949192431, 64'd286745385759,
      64'd305730681459, 64'd324919696233, 64'd344327613290, 64'd363970234266,
      64'd383864035035, 64'd404026225835, 64'd424474816209, 64'd445228685309,
      64'd466307658155, 64'd487732588566, 64'd509525449494, 64'd531709431661,
      64'd554309051453, 64'd577350269190, 64'd600860619028, 64'd624869351910,
      64'd649407593198, 64'd674508516842, 64'd700207538210, 64'd726542528005,
      64'd753554050103, 64'd781285626507, 64'd809784033195, 64'd839099631177,
      64'd869286737816, 64'd900404044298, 64'd932515086138, 64'd965688774807};
    return tbl[d];
  endfunction

  // Whole-degree floor of atan(minor/major) for 0 <= minor <= major.
  function automatic int octant_floor(input longint major, input longint minor);
    int deg;
    deg = 0;
    if (major == 0 || minor == 0) return 0;
    if (major == minor) return 45;
    for (int d = 1; d <= 44; d++)
      if (64'(minor) * 64'd1000000000000 >= tan_scaled(d) * 64'(major)) deg = d;
    return deg;
  endfunction

  // Hue in degrees 0..359 from the offsets to the center.
  // The ceiling equals the floor only on an axis or the diagonal.
  function automatic int wheel_hue(input longint dx, input longint dy);
    longint ax;
    longint ay;
    int lo;
    int hi;
    int fl;
    int cl;
    int fa;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ay <= ax) begin
      fl = octant_floor(ax, ay);
      lo = fl;
      hi = (ay == 0 || ay == ax) ? fl : fl + 1;
    end else begin
      fl = octant_floor(ay, ax);
      cl = (ax == 0) ? fl : fl + 1;
      lo = 90 - cl;
      hi = 90 - fl;
    end
    fa = (dx >= 0) ? lo : 180 - hi;
    if (dy < 0) return (360 - fa) % 360;
    return fa;
  endfunction

  // Integer square root, bit by bit.
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] to_channel(input logic [16:0] x);
    return 8'((64'd255 * x) >> FRAC);
  endfunction

  // Color of one pixel under the shadow configuration.
  function automatic pixel_color_t wheel_color(input logic [11:0] px, input logic [11:0] py);
    pixel_color_t c;
    longint w;
    longint h;
    longint cx;
    longint cy;
    longint r;
    longint dx;
    longint dy;
    logic [63:0] dsq;
    logic [63:0] lim;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] s;
    logic [63:0] f;
    logic [16:0] vp;
    logic [16:0] vq;
    logic [16:0] vt;
    int hue;
    w = width_reg > 4096 ? 4096 : width_reg;
    h = height_reg > 4096 ? 4096 : height_reg;
    cx = w / 2;
    cy = h / 2;
    r = cx < cy ? cx : cy;
    dx = longint'(px) - cx;
    dy = longint'(py) - cy;
    dsq = dx * dx + dy * dy;
    lim = 81 * r * r;
    if (100 * dsq > lim) begin
      c.red = bg_reg[23:16];
      c.green = bg_reg[15:8];
      c.blue = bg_reg[7:0];
      c.on_wheel = 1'b0;
      return c;
    end
    if (lim == 0) begin
      s = 0;
    end else begin
      // Long division of 100*D by the limit, 2*FRAC fraction bits.
      q = (100 * dsq) / lim;
      rem = (100 * dsq) % lim;
      for (int k = 0; k < 2 * FRAC; k++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= lim) begin
          rem -= lim;
          q |= 1;
        end
      end
      s = int_sqrt(q);
    end
    if (s > ONE) s = ONE;
    hue = wheel_hue(dx, dy);
    f = ((hue % 60) << FRAC) / 60;
    vp = 17'(ONE - s);
    vq = 17'(ONE - ((s * f) >> FRAC));
    vt = 17'(ONE - ((s * (ONE - f)) >> FRAC));
    case (hue / 60)
      0: begin c.red = to_channel(ONE); c.green = to_channel(vt); c.blue = to_channel(vp); end
      1: begin c.red = to_channel(vq); c.green = to_channel(ONE); c.blue = to_channel(vp); end
      2: begin c.red = to_channel(vp); c.green = to_channel(ONE); c.blue = to_channel(vt); end
      3: begin c.red = to_channel(vp); c.green = to_channel(vq); c.blue = to_channel(ONE); end
      4: begin c.red = to_channel(vt); c.green = to_channel(vp); c.blue = to_channel(ONE); end
      default: begin
        c.red = to_channel(ONE); c.green = to_channel(vp); c.blue = to_channel(vq);
      end
    endcase
    c.on_wheel = 1'b1;
    return c;
  endfunction

  // Register write over the configuration channel.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CANVAS_WIDTH:  width_reg = val[12:0];
      CFG_CANVAS_HEIGHT: height_reg = val[12:0];
      CFG_BACKGROUND:    bg_reg = val;
      default: ;
    endcase
  endtask

  // Offer one pixel and wait for its transfer.
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    color_queue.push_back(wheel_color(px, py));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Random pixels, mostly near the wheel so both sides of the rim are hit.
  task automatic random_pixels(input int n);
    logic [11:0] px;
    logic [11:0] py;
    int cx;
    int cy;
    int span;
    cx = (width_reg > 4096 ? 4096 : width_reg) / 2;
    cy = (height_reg > 4096 ? 4096 : height_reg) / 2;
    span = (cx < cy ? cx : cy) + 2;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        px = 12'($urandom);
        py = 12'($urandom);
      end else begin
        px = 12'(cx + $urandom_range(2 * span) - span);
        py = 12'(cy + $urandom_range(2 * span) - span);
      end
      send_pixel(px, py);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Result check against the oldest expected color.
  always @(posedge clk) begin
    pixel_color_t got;
    pixel_color_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tuser};
      if (color_queue.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= 10)
          $display("unexpected transfer: %h", got);
      end else begin
        want = color_queue.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d w=%0d, got r=%0d g=%0d b=%0d w=%0d",
                     want.red, want.green, want.blue, want.on_wheel,
                     got.red, got.green, got.blue, got.on_wheel);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_color_wheel_pixel_generator_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t rows[$];
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CANVAS_WIDTH;
    cfg_data = '0;
    hold_off = 1'b0;
    in_idle_pct = 31;
    out_idle_pct = 63;
    mismatch_count = 0;
    unexpected_count = 0;
    quiet_cycles = 0;
    width_reg = CANVAS_RESET;
    height_reg = CANVAS_RESET;
    bg_reg = BG_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset configuration: center 128, radius 128.
    rows = '{
      '{12'd128, 12'd128, 1, '{8'd255, 8'd255, 8'd255, 1'b1}},  // center is white
      '{12'd0, 12'd0, 1, '{8'd255, 8'd255, 8'd255, 1'b0}},      // corner, background
      '{12'hFFF, 12'hFFF, 1, '{8'd255, 8'd255, 8'd255, 1'b0}},  // far off canvas
      '{12'd243, 12'd128, 0, '{0, 0, 0, 0}},  // rim, hue 0
      '{12'd244, 12'd128, 0, '{0, 0, 0, 0}},  // just outside
      '{12'd128, 12'd243, 0, '{0, 0, 0, 0}},  // hue 90
      '{12'd13, 12'd128, 0, '{0, 0, 0, 0}},   // hue 180
      '{12'd128, 12'd13, 0, '{0, 0, 0, 0}},   // hue 270
      '{12'd178, 12'd178, 0, '{0, 0, 0, 0}},  // 45 degrees
      '{12'd78, 12'd78, 0, '{0, 0, 0, 0}},    // 225 degrees
      '{12'd178, 12'd78, 0, '{0, 0, 0, 0}},   // 315 degrees
      '{12'd78, 12'd178, 0, '{0, 0, 0, 0}},   // 135 degrees
      '{12'd200, 12'd170, 0, '{0, 0, 0, 0}},  // sector zero
      '{12'd100, 12'd200, 0, '{0, 0, 0, 0}},  // sector one
      '{12'd60, 12'd110, 0, '{0, 0, 0, 0}},   // sector three
      '{12'd110, 12'd40, 0, '{0, 0, 0, 0}},   // sector four
      '{12'd200, 12'd80, 0, '{0, 0, 0, 0}},   // sector five
      '{12'd129, 12'd128, 0, '{0, 0, 0, 0}},
      '{12'd128, 12'd127, 0, '{0, 0, 0, 0}},
      '{12'hAAA, 12'h555, 0, '{0, 0, 0, 0}},
      '{12'h555, 12'hAAA, 0, '{0, 0, 0, 0}}
    };
    foreach (rows[i]) begin
      send_pixel(rows[i].px, rows[i].py);
      if (rows[i].has_color) color_queue[$] = rows[i].color;
    end
    drain();

    // Degenerate canvases: zero size and zero radius, then oversized.
    write_reg(CFG_CANVAS_WIDTH, 24'd0);
    write_reg(CFG_BACKGROUND, 24'h000000);
    send_pixel(12'd0, 12'd128);
    color_queue[$] = '{8'd255, 8'd255, 8'd255, 1'b1};
    send_pixel(12'd1, 12'd0);
    color_queue[$] = '{8'd0, 8'd0, 8'd0, 1'b0};
    send_pixel(12'd0, 12'd200);
    drain();
    write_reg(CFG_CANVAS_WIDTH, 24'h1FFF);
    write_reg(CFG_CANVAS_HEIGHT, 24'd1);
    send_pixel(12'd0, 12'd0);
    drain();

    // Random phases over several canvases.
    write_reg(CFG_CANVAS_WIDTH, 24'h1FFF);
    write_reg(CFG_CANVAS_HEIGHT, 24'd4096);
    write_reg(CFG_BACKGROUND, 24'hA5C35A);
    random_pixels(300);
    drain();

    in_idle_pct = 63;
    out_idle_pct = 31;
    write_reg(CFG_CANVAS_WIDTH, 24'd640);
    write_reg(CFG_CANVAS_HEIGHT, 24'd480);
    write_reg(CFG_BACKGROUND, 24'h5A3CA5);
    random_pixels(400);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(CFG_CANVAS_WIDTH, 24'd37);
    write_reg(CFG_CANVAS_HEIGHT, 24'd90);
    hold_off = 1'b1;
    fork
      random_pixels(200);
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    write_reg(CFG_CANVAS_WIDTH, 24'd3);
    write_reg(CFG_CANVAS_HEIGHT, 24'd4095);
    random_pixels(100);
    drain();
    write_reg(CFG_CANVAS_WIDTH, 24'd1024);
    write_reg(CFG_CANVAS_HEIGHT, 24'd1024);
    random_pixels(500);
    drain();

    if (mismatch_count == 0 && unexpected_count == 0) begin
      $display("tb_color_wheel_pixel_generator_core: done, clean");
    end else begin
      $display("tb_color_wheel_pixel_generator_core: done, errors");
    end
    $finish;
  end

endmodule
